@@ rtl/bucc_pkg.sv @@
`default_nettype none

package bucc_pkg;

  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // Up to three output bytes per input transaction
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0]                  count;
    logic [MaxResults-1:0][7:0]  bytes;
  } group_t;

  localparam int unsigned QueueDepth = 2;

endpackage

`default_nettype wire

@@ rtl/bucc_front.sv @@
`default_nettype none

module bucc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bucc_pkg::in_item_t in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output bucc_pkg::group_t   group_o
);
  import bucc_pkg::*;

  // UTF-8 sequence length from a lead byte; stray leads count as one
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] n;
    if (!c[7]) begin
      n = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      n = 3'd4;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  function automatic logic [8:0] map_fwd(input logic [7:0] b);
    logic [8:0] r;
    if (b inside {[8'd33:8'd126], [8'd161:8'd172], [8'd174:8'd255]}) begin
      r = {1'b0, b};
    end else if (b < 8'd33) begin
      r = {1'b1, b};
    end else if (b <= 8'd160) begin
      r = {1'b0, b} + 9'd162;
    end else begin
      r = 9'd323;
    end
    return r;
  endfunction

  // Returns {ok, byte}
  function automatic logic [8:0] map_back(input logic [20:0] cp);
    logic [8:0] r;
    logic [8:0] lo;
    lo = cp[8:0];
    r  = '0;
    if (cp[20:9] == 12'd0) begin
      if (lo inside {[9'd33:9'd126], [9'd161:9'd172], [9'd174:9'd288]}) begin
        r = {1'b1, lo[7:0]};
      end else if (lo inside {[9'd289:9'd322]}) begin
        r = {1'b1, lo[7:0] + 8'd94};
      end else if (lo == 9'd323) begin
        r = {1'b1, 8'd173};
      end
    end
    return r;
  endfunction

  function automatic logic [20:0] assemble(input logic [2:0] need,
                                           input logic [7:0] b0,
                                           input logic [7:0] b1,
                                           input logic [7:0] b2,
                                           input logic [7:0] b3);
    logic [20:0] cp;
    case (need)
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4:    cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  mode_e      mode_q;
  logic [1:0] cnt_q, cnt_d;
  logic [7:0] pend_q [3];
  logic       pend_we;

  logic       accept;
  logic [7:0] b0, b1, b2, b3;
  logic [2:0] n, need0, tail_len;
  logic [8:0] cp_fwd;
  logic [8:0] r0, r1, r2;
  logic [2:0] slot_v;
  logic [7:0] slot_b [3];
  logic [1:0] k;
  group_t     group;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  // Concatenated view of pending bytes followed by the new byte
  assign b0 = (cnt_q == 2'd0) ? in_data_i.in_byte : pend_q[0];
  assign b1 = (cnt_q <= 2'd1) ? in_data_i.in_byte : pend_q[1];
  assign b2 = (cnt_q <= 2'd2) ? in_data_i.in_byte : pend_q[2];
  assign b3 = in_data_i.in_byte;

  assign n        = {1'b0, cnt_q} + 3'd1;
  assign need0    = seq_len(b0);
  assign tail_len = n - 3'd1;
  assign cp_fwd   = map_fwd(in_data_i.in_byte);

  always_comb begin
    r0      = '0;
    r1      = '0;
    r2      = '0;
    cnt_d   = cnt_q;
    pend_we = 1'b0;
    if (mode_q == ModeEncode) begin
      if (cp_fwd[8:7] == 2'b00) begin
        r0 = {1'b1, cp_fwd[7:0]};
      end else begin
        r0 = {1'b1, 5'b11000, cp_fwd[8:6]};
        r1 = {1'b1, 2'b10, cp_fwd[5:0]};
      end
    end else if (need0 <= n) begin
      r0    = map_back(assemble(need0, b0, b1, b2, b3));
      cnt_d = 2'd0;
    end else if (in_data_i.end_of_text) begin
      // truncated sequence: lead stands alone, the rest is decoded again
      r0    = map_back({13'd0, b0});
      cnt_d = 2'd0;
      if (tail_len == 3'd1) begin
        r1 = map_back({13'd0, b1});
      end else if (tail_len == 3'd2) begin
        if (seq_len(b1) == 3'd2) begin
          r1 = map_back(assemble(3'd2, b1, b2, 8'd0, 8'd0));
        end else begin
          r1 = map_back({13'd0, b1});
          r2 = map_back({13'd0, b2});
        end
      end
    end else begin
      pend_we = 1'b1;
      cnt_d   = n[1:0];
    end
  end

  assign slot_v    = {r2[8], r1[8], r0[8]};
  assign slot_b[0] = r0[7:0];
  assign slot_b[1] = r1[7:0];
  assign slot_b[2] = r2[7:0];

  // Pack the surviving bytes to the front
  always_comb begin
    group = '0;
    k     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      if (slot_v[i]) begin
        group.bytes[k] = slot_b[i];
        k              = k + 2'd1;
      end
    end
    group.count = k;
  end

  assign push_o  = accept & (group.count != 2'd0);
  assign group_o = group;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
      cnt_q  <= 2'd0;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
      cnt_q  <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pend_we) begin
      case (cnt_q)
        2'd0:    pend_q[0] <= in_data_i.in_byte;
        2'd1:    pend_q[1] <= in_data_i.in_byte;
        2'd2:    pend_q[2] <= in_data_i.in_byte;
        default: pend_q[0] <= pend_q[0];
      endcase
    end
  end

  // Buffered bytes are always a lead still short of its full length
  a_pending_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (seq_len(pend_q[0]) > {1'b0, cnt_q}))
    else $error("pending sequence already complete");

endmodule

`default_nettype wire

@@ rtl/bucc_queue.sv @@
`default_nettype none

module bucc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bucc_pkg::group_t group_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output bucc_pkg::group_t head_o
);
  import bucc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  group_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= group_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ rtl/bucc_back.sv @@
`default_nettype none

module bucc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  bucc_pkg::group_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bucc_pkg::out_item_t out_data_o
);
  import bucc_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       last;
  logic       fire;

  assign last        = (idx_q == head_i.count - 2'd1);
  assign fire        = head_valid_i & ~out_stall_i;
  assign pop_o       = fire & last;
  assign out_valid_o = head_valid_i;

  assign out_data_o.out_byte = head_i.bytes[idx_q];
  assign out_data_o.run_last = last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < head_i.count))
    else $error("byte index past end of group");

endmodule

`default_nettype wire

@@ rtl/byte_unicode_utf8_codec_core.sv @@
// The front pushes each transaction's result bytes into a registered result queue.
// Throughput: one input transaction per cycle while that queue is not full; output
// is one byte per cycle while out_stall_i is low, so multi-byte results can stall input.
// The two-entry result queue between front and back sets how far input runs ahead.
// Reset: encode mode, no buffered UTF-8 bytes, queue empty. No clearing pass.
`default_nettype none

module byte_unicode_utf8_codec_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bucc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bucc_pkg::out_item_t out_data_o
);
  import bucc_pkg::*;

  logic   push, full, pop, head_valid;
  group_t push_group, head_group;

  // Mode writes must only happen while idle (the user's duty, not enforced); they are always taken
  assign cfg_ready_o = 1'b1;

  bucc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .group_o     (push_group)
  );

  bucc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .group_i (push_group),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_group)
  );

  bucc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_group),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

@@ verif/codec_checker.sv @@
module codec_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  bucc_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  bucc_pkg::out_item_t out_data_i,
  output int                  errors_o,
  output int                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bucc_pkg::*;

  mode_e       mode_q;
  logic [7:0]  held_q [3];
  int unsigned held_cnt;
  out_item_t   exp_bytes_q [$];

  // Printable bytes keep their value, the rest go to 256 upward in byte order
  function automatic int unsigned cp_of_byte(input logic [7:0] b);
    int unsigned v;
    v = b;
    if ((v >= 33 && v <= 126) || (v >= 161 && v <= 172) || v >= 174) return v;
    if (v < 33) return 256 + v;
    if (v <= 160) return 289 + (v - 127);
    return 323;
  endfunction

  function automatic bit byte_of_cp(input int unsigned cp, output logic [7:0] b);
    b = '0;
    if (cp >= 512) return 1'b0;
    if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) ||
        (cp >= 174 && cp <= 255)) begin
      b = cp[7:0];
      return 1'b1;
    end
    if (cp >= 256 && cp <= 288) begin
      b = 8'(cp - 256);
      return 1'b1;
    end
    if (cp >= 289 && cp <= 322) begin
      b = 8'(cp - 289 + 127);
      return 1'b1;
    end
    if (cp == 323) begin
      b = 8'd173;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Stray continuation bytes and 0xF8+ stand alone
  function automatic int unsigned lead_len(input logic [7:0] c);
    if (c < 8'h80) return 1;
    if ((c & 8'hE0) == 8'hC0) return 2;
    if ((c & 8'hF0) == 8'hE0) return 3;
    if ((c & 8'hF8) == 8'hF0) return 4;
    return 1;
  endfunction

  task automatic report(input string what, input int unsigned got_v,
                        input int unsigned exp_v);
    if (errors_o < 40)
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got_v, exp_v);
    errors_o++;
  endtask

  task automatic predict_bytes(input in_item_t it);
    logic [7:0]  seq_b [4];
    logic [7:0]  res [$];
    logic [7:0]  b;
    int unsigned cp, n, pos, need;
    out_item_t   r;
    if (mode_q == ModeEncode) begin
      cp = cp_of_byte(it.in_byte);
      if (cp <= 'h7F) begin
        res.push_back(cp[7:0]);
      end else begin
        res.push_back(8'(8'hC0 | (cp >> 6)));
        res.push_back(8'(8'h80 | (cp & 'h3F)));
      end
    end else begin
      for (int i = 0; i < held_cnt; i++) seq_b[i] = held_q[i];
      seq_b[held_cnt] = it.in_byte;
      n = held_cnt + 1;
      pos = 0;
      while (pos < n) begin
        need = lead_len(seq_b[pos]);
        if (pos + need <= n) begin
          case (need)
            1: cp = seq_b[pos];
            2: cp = {seq_b[pos][4:0], seq_b[pos+1][5:0]};
            3: cp = {seq_b[pos][3:0], seq_b[pos+1][5:0], seq_b[pos+2][5:0]};
            default: cp = {seq_b[pos][2:0], seq_b[pos+1][5:0],
                           seq_b[pos+2][5:0], seq_b[pos+3][5:0]};
          endcase
          pos += need;
        end else if (it.end_of_text) begin
          // short sequence at end of text: lead taken as its own value,
          // the rest rescanned from the next byte
          cp = seq_b[pos];
          pos += 1;
        end else begin
          break;
        end
        if (byte_of_cp(cp, b) && res.size() < MaxResults) res.push_back(b);
      end
      held_cnt = 0;
      while (pos < n && held_cnt < 3) begin
        held_q[held_cnt] = seq_b[pos];
        held_cnt++;
        pos++;
      end
    end
    foreach (res[i]) begin
      r.out_byte = res[i];
      r.run_last = (i == res.size() - 1);
      exp_bytes_q.push_back(r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      mode_q = ModeEncode;
      held_cnt = 0;
      exp_bytes_q.delete();
      errors_o = 0;
      outstanding_o = 0;
    end else begin
      // results first: one accepted this edge stems from an earlier transaction
      if (out_valid_i && !out_stall_i) begin
        if (exp_bytes_q.size() == 0) begin
          report("unexpected result byte", out_data_i.out_byte, 0);
        end else begin
          want = exp_bytes_q.pop_front();
          if (out_data_i.out_byte !== want.out_byte)
            report("out_byte", out_data_i.out_byte, want.out_byte);
          if (out_data_i.run_last !== want.run_last)
            report("run_last", out_data_i.run_last, want.run_last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q = mode_e'(cfg_data_i);
        held_cnt = 0;
      end
      if (in_valid_i && !in_stall_i) predict_bytes(in_data_i);
      outstanding_o = exp_bytes_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bucc_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_data_i = 1'b0;
  logic      cfg_ready_o;
  logic      in_valid_i = 1'b0;
  in_item_t  in_data_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  int errors;
  int outstanding;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int sent_items;

  byte_unicode_utf8_codec_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  codec_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_i    (out_data_o),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  task automatic send_item(input logic [7:0] b, input logic eot);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{in_byte: b, end_of_text: eot};
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  // hold off input until every predicted byte is out, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(input mode_e m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly well-formed UTF-8 with random payload, some noise bytes
  task automatic send_sequence();
    int unsigned kind, len;
    logic [7:0]  lead;
    kind = $urandom_range(99);
    len  = 1;
    if (kind < 20) begin
      lead = 8'($urandom_range(127));
    end else if (kind < 65) begin
      lead = ($urandom_range(4) != 0) ? 8'($urandom_range(8'hC5, 8'hC2))
                                      : 8'(8'hC0 | $urandom_range(31));
      len = 2;
    end else if (kind < 75) begin
      lead = 8'(8'hE0 | $urandom_range(15));
      len = 3;
    end else if (kind < 85) begin
      lead = 8'(8'hF0 | $urandom_range(7));
      len = 4;
    end else begin
      lead = 8'($urandom_range(255));
    end
    send_item(lead, $urandom_range(19) == 0);
    for (int i = 1; i < len; i++)
      send_item(($urandom_range(7) != 0) ? 8'(8'h80 | $urandom_range(63))
                                         : 8'($urandom_range(255)),
                $urandom_range(19) == 0);
  endtask

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // encode: range edges of the byte map, end_of_text toggled
    write_mode(ModeEncode);
    send_item(8'd0,   1'b0);
    send_item(8'd32,  1'b1);
    send_item(8'd33,  1'b0);
    send_item(8'd126, 1'b1);
    send_item(8'd127, 1'b0);
    send_item(8'd160, 1'b1);
    send_item(8'd172, 1'b0);
    send_item(8'd173, 1'b1);
    send_item(8'd255, 1'b0);

    write_mode(ModeDecode);
    send_item(8'h41, 1'b0);
    send_item(8'hC4, 1'b0);   // U+0100 -> 0x00
    send_item(8'h80, 1'b0);
    send_item(8'hC5, 1'b0);   // U+0143 -> 0xAD
    send_item(8'h83, 1'b0);
    send_item(8'hC5, 1'b0);   // U+0144, no byte
    send_item(8'h84, 1'b0);
    send_item(8'hF0, 1'b0);   // overlong four-byte form of '!'
    send_item(8'h80, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hA1, 1'b0);
    send_item(8'h80, 1'b0);   // stray continuation, unmapped
    send_item(8'hFF, 1'b0);   // stray lead, maps to itself
    send_item(8'hF0, 1'b0);   // truncated by end of text: three bytes back
    send_item(8'hA1, 1'b0);
    send_item(8'hB2, 1'b1);
    send_item(8'hE2, 1'b0);   // left pending, then dropped by the mode write
    write_mode(ModeDecode);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 46; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 46; end
        default: begin in_idle_pct = 29; out_stall_pct = 29; end
      endcase
      write_mode(ModeEncode);
      sent_items = 0;
      while (sent_items < 30) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
      write_mode(ModeDecode);
      sent_items = 0;
      while (sent_items < 50) send_sequence();
    end

    drain();
    if (errors == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
